### design/iqh_pkg.sv
// ----------------------------------------------------------------------------
// iqh_pkg
// Shared widths, reset values, command codes and control types of the
// I/Q histogram and moment accumulator.
// ----------------------------------------------------------------------------
package iqh_pkg;

  localparam int unsigned HistBins     = 256;
  localparam int unsigned HistAddrW    = $clog2(HistBins);
  localparam int unsigned CountBitsDef = 32;
  localparam int unsigned SampleW      = 8;
  localparam int unsigned SqW          = 2 * SampleW;
  localparam int unsigned SumW         = 40;
  localparam int unsigned SqSumW       = 48;
  localparam int unsigned OutCntW      = 32;
  localparam int unsigned SplW         = 16;
  localparam int unsigned DecW         = 8;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 16;

  localparam logic [SplW-1:0] SplReset = 16'd1024;
  localparam logic [DecW-1:0] DecReset = 8'd10;

  localparam logic [CfgIdxW-1:0] RegSamplesPerLine = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLineDecimation = 2'd1;

  typedef enum logic [1:0] {
    CmdSample  = 2'd0,
    CmdReadBin = 2'd1,
    CmdReadTot = 2'd2,
    CmdClear   = 2'd3
  } cmd_e;

  // update strobes issued by the read-modify-write stage
  typedef struct packed {
    logic incr;
    logic clear;
  } upd_t;

endpackage

### design/iqh_hist_bank.sv
// ----------------------------------------------------------------------------
// iqh_hist_bank
// One 256-bin histogram: synchronous memory with registered read, per-bin
// valid flags for instant clear, forwarding of the bin written in the same
// cycle as the read, and a saturating increment written back.
// ----------------------------------------------------------------------------
module iqh_hist_bank #(
  parameter int unsigned CntW = iqh_pkg::CountBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [iqh_pkg::HistAddrW-1:0] rd_addr_i,
  input  iqh_pkg::upd_t                 upd_i,
  output logic [CntW-1:0]               cnt_o
);

  logic [CntW-1:0]               mem_q [iqh_pkg::HistBins];
  logic [iqh_pkg::HistBins-1:0]  vld_q;
  logic [CntW-1:0]               rdata_q;
  logic [iqh_pkg::HistAddrW-1:0] addr_q;
  logic                          ent_vld_q;
  logic                          fwd_q;
  logic [CntW-1:0]               fwd_data_q;
  logic [CntW-1:0]               wr_data;

  // resolved count of the bin held in the update stage
  assign cnt_o   = fwd_q ? fwd_data_q : (ent_vld_q ? rdata_q : '0);
  assign wr_data = (&cnt_o) ? cnt_o : cnt_o + CntW'(1);

  always_ff @(posedge clk_i) begin
    if (upd_i.incr) begin
      mem_q[addr_q] <= wr_data;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      addr_q     <= rd_addr_i;
      fwd_data_q <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      ent_vld_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      if (upd_i.clear) begin
        vld_q <= '0;
      end else if (upd_i.incr) begin
        vld_q[addr_q] <= 1'b1;
      end
      if (rd_en_i) begin
        // a clear in flight wipes what the new read sees
        ent_vld_q <= vld_q[rd_addr_i] && !upd_i.clear;
        fwd_q     <= upd_i.incr && (addr_q == rd_addr_i);
      end
    end
  end

endmodule

### design/iqh_moments.sv
// ----------------------------------------------------------------------------
// iqh_moments
// Line position tracking with decimation, saturating sums, sums of squares
// and the count of accumulated pairs.
// ----------------------------------------------------------------------------
module iqh_moments #(
  parameter int unsigned CntW = iqh_pkg::CountBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  iqh_pkg::upd_t               upd_i,
  input  logic [iqh_pkg::SampleW-1:0] i_val_i,
  input  logic [iqh_pkg::SampleW-1:0] q_val_i,
  input  logic [iqh_pkg::SqW-1:0]     i_sq_i,
  input  logic [iqh_pkg::SqW-1:0]     q_sq_i,
  input  logic [iqh_pkg::SplW-1:0]    spl_i,
  input  logic [iqh_pkg::DecW-1:0]    dec_i,
  output logic                        accum_o,
  output logic [iqh_pkg::SumW-1:0]    i_sum_o,
  output logic [iqh_pkg::SumW-1:0]    q_sum_o,
  output logic [iqh_pkg::SqSumW-1:0]  i_sq_sum_o,
  output logic [iqh_pkg::SqSumW-1:0]  q_sq_sum_o,
  output logic [CntW-1:0]             pair_cnt_o
);

  logic [iqh_pkg::SumW-1:0]   i_sum_q, i_sum_d, q_sum_q, q_sum_d;
  logic [iqh_pkg::SqSumW-1:0] i_sq_q, i_sq_d, q_sq_q, q_sq_d;
  logic [CntW-1:0]            pair_q, pair_d;
  logic [iqh_pkg::SplW-1:0]   sil_q, sil_d, spl_eff;
  logic [iqh_pkg::DecW-1:0]   phase_q, phase_d, dec_eff;
  logic [iqh_pkg::SumW:0]     i_sum_w, q_sum_w;
  logic [iqh_pkg::SqSumW:0]   i_sq_w, q_sq_w;
  logic                       line_end, phase_wrap;

  assign spl_eff = (spl_i == '0) ? iqh_pkg::SplW'(1) : spl_i;
  assign dec_eff = (dec_i == '0) ? iqh_pkg::DecW'(1) : dec_i;

  assign line_end   = ({1'b0, sil_q} + (iqh_pkg::SplW + 1)'(1)) >= {1'b0, spl_eff};
  assign phase_wrap = ({1'b0, phase_q} + (iqh_pkg::DecW + 1)'(1)) >= {1'b0, dec_eff};

  assign accum_o = (phase_q == '0);

  // carry out of the widened add means saturation
  assign i_sum_w = {1'b0, i_sum_q} + (iqh_pkg::SumW + 1)'(i_val_i);
  assign q_sum_w = {1'b0, q_sum_q} + (iqh_pkg::SumW + 1)'(q_val_i);
  assign i_sq_w  = {1'b0, i_sq_q} + (iqh_pkg::SqSumW + 1)'(i_sq_i);
  assign q_sq_w  = {1'b0, q_sq_q} + (iqh_pkg::SqSumW + 1)'(q_sq_i);

  always_comb begin
    i_sum_d = i_sum_q;
    q_sum_d = q_sum_q;
    i_sq_d  = i_sq_q;
    q_sq_d  = q_sq_q;
    pair_d  = pair_q;
    sil_d   = sil_q;
    phase_d = phase_q;
    if (upd_i.clear) begin
      i_sum_d = '0;
      q_sum_d = '0;
      i_sq_d  = '0;
      q_sq_d  = '0;
      pair_d  = '0;
      sil_d   = '0;
      phase_d = '0;
    end else if (upd_i.incr) begin
      if (accum_o) begin
        i_sum_d = i_sum_w[iqh_pkg::SumW] ? '1 : i_sum_w[iqh_pkg::SumW-1:0];
        q_sum_d = q_sum_w[iqh_pkg::SumW] ? '1 : q_sum_w[iqh_pkg::SumW-1:0];
        i_sq_d  = i_sq_w[iqh_pkg::SqSumW] ? '1 : i_sq_w[iqh_pkg::SqSumW-1:0];
        q_sq_d  = q_sq_w[iqh_pkg::SqSumW] ? '1 : q_sq_w[iqh_pkg::SqSumW-1:0];
        pair_d  = (&pair_q) ? pair_q : pair_q + CntW'(1);
      end
      if (line_end) begin
        sil_d   = '0;
        phase_d = phase_wrap ? '0 : phase_q + iqh_pkg::DecW'(1);
      end else begin
        sil_d = sil_q + iqh_pkg::SplW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_sum_q <= '0;
      q_sum_q <= '0;
      i_sq_q  <= '0;
      q_sq_q  <= '0;
      pair_q  <= '0;
      sil_q   <= '0;
      phase_q <= '0;
    end else begin
      i_sum_q <= i_sum_d;
      q_sum_q <= q_sum_d;
      i_sq_q  <= i_sq_d;
      q_sq_q  <= q_sq_d;
      pair_q  <= pair_d;
      sil_q   <= sil_d;
      phase_q <= phase_d;
    end
  end

  assign i_sum_o    = i_sum_q;
  assign q_sum_o    = q_sum_q;
  assign i_sq_sum_o = i_sq_q;
  assign q_sq_sum_o = q_sq_q;
  assign pair_cnt_o = pair_q;

endmodule

### design/iq_histogram_moment_accumulator_core.sv
// ----------------------------------------------------------------------------
// iq_histogram_moment_accumulator_core
// Usage: feed words on the input channel (command, I/Q bytes, bin index).
// Sample words on lines whose decimation phase is zero update two 256-bin
// histograms, the sums, the sums of squares and the pair count. Read-bin and
// read-totals words each return one result word; sample and clear words
// return nothing. Registers samples_per_line and line_decimation are written
// on the config channel while the block is idle; the user must see to this,
// the block does not enforce it. Throughput: one word per cycle unless the
// input stalls, set by the single read-modify-write pass through each memory
// (read in the accept cycle; written back, and any result word registered,
// as the word leaves the update stage; same-bin collisions forwarded).
// Reset: all sums and counters return to zero and the histograms read as
// zero at once through per-bin valid flags, so no clearing pass is needed;
// a clear word does the same without touching the registers.
// Output stall: the output register holds its word; sample and clear words
// keep flowing, and input stall rises only when a further read word needs
// the output register.
// ----------------------------------------------------------------------------
module iq_histogram_moment_accumulator_core #(
  parameter int unsigned COUNT_BITS = iqh_pkg::CountBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [iqh_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [iqh_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   command_i,
  input  logic [7:0]                   i_sample_i,
  input  logic [7:0]                   q_sample_i,
  input  logic [7:0]                   bin_index_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [31:0]                  i_bin_count_o,
  output logic [31:0]                  q_bin_count_o,
  output logic [39:0]                  i_total_o,
  output logic [39:0]                  q_total_o,
  output logic [47:0]                  i_square_total_o,
  output logic [47:0]                  q_square_total_o,
  output logic [31:0]                  pairs_counted_o
);

  logic [iqh_pkg::SplW-1:0] spl_q;
  logic [iqh_pkg::DecW-1:0] dec_q;

  iqh_pkg::cmd_e              in_cmd, s1_cmd_q;
  logic                       s1_valid_q, s1_valid_d;
  logic [iqh_pkg::SampleW-1:0] s1_i_q, s1_q_q;
  logic [iqh_pkg::SqW-1:0]    s1_isq_q, s1_qsq_q;
  logic                       s1_needs_out, s1_adv, accept;
  logic [iqh_pkg::HistAddrW-1:0] i_addr, q_addr;
  iqh_pkg::upd_t              mom_upd, hist_upd;
  logic                       accum;

  logic [COUNT_BITS-1:0]      i_cnt, q_cnt, pair_cnt;
  logic [iqh_pkg::OutCntW-1:0] i_cnt32, q_cnt32, pair_cnt32;
  logic [iqh_pkg::SumW-1:0]   i_sum, q_sum;
  logic [iqh_pkg::SqSumW-1:0] i_sq_sum, q_sq_sum;

  logic                       out_valid_q;
  logic [iqh_pkg::OutCntW-1:0] out_ibin_q, out_qbin_q, out_pairs_q;
  logic [iqh_pkg::SumW-1:0]   out_isum_q, out_qsum_q;
  logic [iqh_pkg::SqSumW-1:0] out_isq_q, out_qsq_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spl_q <= iqh_pkg::SplReset;
      dec_q <= iqh_pkg::DecReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        iqh_pkg::RegSamplesPerLine: spl_q <= cfg_data_i;
        iqh_pkg::RegLineDecimation: dec_q <= cfg_data_i[iqh_pkg::DecW-1:0];
        default: ;
      endcase
    end
  end

  // input handshake and update stage control
  assign in_cmd       = iqh_pkg::cmd_e'(command_i);
  assign s1_needs_out = (s1_cmd_q == iqh_pkg::CmdReadBin) ||
                        (s1_cmd_q == iqh_pkg::CmdReadTot);
  assign s1_adv       = s1_valid_q && (!s1_needs_out || !out_valid_q || !out_stall_i);
  assign in_stall_o   = s1_valid_q && !s1_adv;
  assign accept       = in_valid_i && !in_stall_o;

  assign i_addr = (in_cmd == iqh_pkg::CmdReadBin) ? bin_index_i : i_sample_i;
  assign q_addr = (in_cmd == iqh_pkg::CmdReadBin) ? bin_index_i : q_sample_i;

  assign mom_upd.incr   = s1_adv && (s1_cmd_q == iqh_pkg::CmdSample);
  assign mom_upd.clear  = s1_adv && (s1_cmd_q == iqh_pkg::CmdClear);
  assign hist_upd.incr  = mom_upd.incr && accum;
  assign hist_upd.clear = mom_upd.clear;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_cmd_q   <= iqh_pkg::CmdSample;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (accept) begin
        s1_cmd_q <= in_cmd;
      end
    end
  end

  // square the samples on the way in
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_i_q   <= i_sample_i;
      s1_q_q   <= q_sample_i;
      s1_isq_q <= iqh_pkg::SqW'(i_sample_i) * iqh_pkg::SqW'(i_sample_i);
      s1_qsq_q <= iqh_pkg::SqW'(q_sample_i) * iqh_pkg::SqW'(q_sample_i);
    end
  end

  iqh_hist_bank #(
    .CntW (COUNT_BITS)
  ) u_i_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (i_addr),
    .upd_i     (hist_upd),
    .cnt_o     (i_cnt)
  );

  iqh_hist_bank #(
    .CntW (COUNT_BITS)
  ) u_q_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (q_addr),
    .upd_i     (hist_upd),
    .cnt_o     (q_cnt)
  );

  iqh_moments #(
    .CntW (COUNT_BITS)
  ) u_moments (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (mom_upd),
    .i_val_i    (s1_i_q),
    .q_val_i    (s1_q_q),
    .i_sq_i     (s1_isq_q),
    .q_sq_i     (s1_qsq_q),
    .spl_i      (spl_q),
    .dec_i      (dec_q),
    .accum_o    (accum),
    .i_sum_o    (i_sum),
    .q_sum_o    (q_sum),
    .i_sq_sum_o (i_sq_sum),
    .q_sq_sum_o (q_sq_sum),
    .pair_cnt_o (pair_cnt)
  );

  // fit counters to the 32-bit result fields
  if (COUNT_BITS > iqh_pkg::OutCntW) begin : g_sat
    assign i_cnt32    = (|i_cnt[COUNT_BITS-1:iqh_pkg::OutCntW]) ? '1 :
                        i_cnt[iqh_pkg::OutCntW-1:0];
    assign q_cnt32    = (|q_cnt[COUNT_BITS-1:iqh_pkg::OutCntW]) ? '1 :
                        q_cnt[iqh_pkg::OutCntW-1:0];
    assign pair_cnt32 = (|pair_cnt[COUNT_BITS-1:iqh_pkg::OutCntW]) ? '1 :
                        pair_cnt[iqh_pkg::OutCntW-1:0];
  end else begin : g_ext
    assign i_cnt32    = iqh_pkg::OutCntW'(i_cnt);
    assign q_cnt32    = iqh_pkg::OutCntW'(q_cnt);
    assign pair_cnt32 = iqh_pkg::OutCntW'(pair_cnt);
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_needs_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_needs_out) begin
      if (s1_cmd_q == iqh_pkg::CmdReadBin) begin
        out_ibin_q  <= i_cnt32;
        out_qbin_q  <= q_cnt32;
        out_isum_q  <= '0;
        out_qsum_q  <= '0;
        out_isq_q   <= '0;
        out_qsq_q   <= '0;
        out_pairs_q <= '0;
      end else begin
        out_ibin_q  <= '0;
        out_qbin_q  <= '0;
        out_isum_q  <= i_sum;
        out_qsum_q  <= q_sum;
        out_isq_q   <= i_sq_sum;
        out_qsq_q   <= q_sq_sum;
        out_pairs_q <= pair_cnt32;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign i_bin_count_o    = out_ibin_q;
  assign q_bin_count_o    = out_qbin_q;
  assign i_total_o        = out_isum_q;
  assign q_total_o        = out_qsum_q;
  assign i_square_total_o = out_isq_q;
  assign q_square_total_o = out_qsq_q;
  assign pairs_counted_o  = out_pairs_q;

`ifndef NO_ASSERTIONS
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i && s1_needs_out))
    else $error("input stalled without a blocked read word");

  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mom_upd.clear |=> (pair_cnt == '0 && i_sum == '0 && q_sum == '0))
    else $error("clear did not zero the totals");

  a_pair_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mom_upd.clear |=> (pair_cnt >= $past(pair_cnt)))
    else $error("pair count went down without a clear");

  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_ibin_q == '0 && out_qbin_q == '0) ||
                     (out_isum_q == '0 && out_qsum_q == '0 && out_pairs_q == '0)))
    else $error("result word mixes bin and total fields");
`endif

endmodule

### dv/iqh_stats_checker.sv
// ----------------------------------------------------------------------------
// iqh_stats_checker
// Watches the config, input and output channels of the I/Q histogram and
// moment accumulator. Keeps its own copy of the histograms, sums, line
// counters and registers, predicts the response word of every read word it
// sees accepted, and compares each accepted output word field by field.
// ----------------------------------------------------------------------------
module iqh_stats_checker #(
  parameter int unsigned CountBits = iqh_pkg::CountBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [iqh_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [iqh_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [1:0]                   command_i,
  input  logic [7:0]                   i_sample_i,
  input  logic [7:0]                   q_sample_i,
  input  logic [7:0]                   bin_index_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [31:0]                  i_bin_count_i,
  input  logic [31:0]                  q_bin_count_i,
  input  logic [39:0]                  i_total_i,
  input  logic [39:0]                  q_total_i,
  input  logic [47:0]                  i_square_total_i,
  input  logic [47:0]                  q_square_total_i,
  input  logic [31:0]                  pairs_counted_i,
  output int unsigned                  pending_o,
  output int unsigned                  mismatches_o
);

  typedef struct packed {
    logic [31:0]                i_bin;
    logic [31:0]                q_bin;
    logic [iqh_pkg::SumW-1:0]   i_tot;
    logic [iqh_pkg::SumW-1:0]   q_tot;
    logic [iqh_pkg::SqSumW-1:0] i_sq;
    logic [iqh_pkg::SqSumW-1:0] q_sq;
    logic [31:0]                pairs;
  } read_word_t;

  localparam logic [63:0] SumTop = (64'd1 << iqh_pkg::SumW) - 64'd1;
  localparam logic [63:0] SqTop  = (64'd1 << iqh_pkg::SqSumW) - 64'd1;
  localparam logic [63:0] CntTop = (64'd1 << CountBits) - 64'd1;

  logic [iqh_pkg::SplW-1:0]   spl_reg;
  logic [iqh_pkg::DecW-1:0]   dec_reg;
  logic [CountBits-1:0]       i_hist [iqh_pkg::HistBins];
  logic [CountBits-1:0]       q_hist [iqh_pkg::HistBins];
  logic [iqh_pkg::SumW-1:0]   i_sum, q_sum;
  logic [iqh_pkg::SqSumW-1:0] i_sum_sq, q_sum_sq;
  logic [iqh_pkg::SplW-1:0]   sample_in_line;
  logic [iqh_pkg::DecW-1:0]   line_phase;
  logic [CountBits-1:0]       pair_count;

  read_word_t pending_reads [$];

  function automatic logic [63:0] sat_add(logic [63:0] acc, logic [63:0] inc,
                                          logic [63:0] top);
    return (acc >= top || inc > top - acc) ? top : acc + inc;
  endfunction

  function automatic logic [31:0] clip32(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  task automatic clear_stats();
    for (int b = 0; b < iqh_pkg::HistBins; b++) begin
      i_hist[b] = '0;
      q_hist[b] = '0;
    end
    i_sum          = '0;
    q_sum          = '0;
    i_sum_sq       = '0;
    q_sum_sq       = '0;
    sample_in_line = '0;
    line_phase     = '0;
    pair_count     = '0;
  endtask

  // advance the statistics by one accepted input word
  task automatic apply_word(iqh_pkg::cmd_e cmd, logic [7:0] iv, logic [7:0] qv,
                            logic [7:0] bv);
    read_word_t               rw;
    logic [iqh_pkg::SplW-1:0] spl_eff;
    logic [iqh_pkg::DecW-1:0] dec_eff;
    rw = '0;
    case (cmd)
      iqh_pkg::CmdSample: begin
        spl_eff = (spl_reg == '0) ? iqh_pkg::SplW'(1) : spl_reg;
        dec_eff = (dec_reg == '0) ? iqh_pkg::DecW'(1) : dec_reg;
        if (line_phase == '0) begin
          i_sum      = iqh_pkg::SumW'(sat_add(64'(i_sum), 64'(iv), SumTop));
          q_sum      = iqh_pkg::SumW'(sat_add(64'(q_sum), 64'(qv), SumTop));
          i_sum_sq   = iqh_pkg::SqSumW'(sat_add(64'(i_sum_sq), 64'(iv) * 64'(iv),
                                                SqTop));
          q_sum_sq   = iqh_pkg::SqSumW'(sat_add(64'(q_sum_sq), 64'(qv) * 64'(qv),
                                                SqTop));
          i_hist[iv] = CountBits'(sat_add(64'(i_hist[iv]), 64'd1, CntTop));
          q_hist[qv] = CountBits'(sat_add(64'(q_hist[qv]), 64'd1, CntTop));
          pair_count = CountBits'(sat_add(64'(pair_count), 64'd1, CntTop));
        end
        if (17'(sample_in_line) + 17'd1 >= 17'(spl_eff)) begin
          sample_in_line = '0;
          if (9'(line_phase) + 9'd1 >= 9'(dec_eff)) line_phase = '0;
          else line_phase = line_phase + iqh_pkg::DecW'(1);
        end else begin
          sample_in_line = sample_in_line + iqh_pkg::SplW'(1);
        end
      end
      iqh_pkg::CmdClear: clear_stats();
      iqh_pkg::CmdReadBin: begin
        rw.i_bin = clip32(64'(i_hist[bv]));
        rw.q_bin = clip32(64'(q_hist[bv]));
        pending_reads.push_back(rw);
      end
      default: begin
        rw.i_tot = i_sum;
        rw.q_tot = q_sum;
        rw.i_sq  = i_sum_sq;
        rw.q_sq  = q_sum_sq;
        rw.pairs = clip32(64'(pair_count));
        pending_reads.push_back(rw);
      end
    endcase
  endtask

  task automatic flag(string what, logic [63:0] want, logic [63:0] got);
    if (mismatches_o < 10)
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
    mismatches_o++;
  endtask

  task automatic check_word(read_word_t got);
    read_word_t want;
    if (pending_reads.size() == 0) begin
      if (mismatches_o < 10) $display("%0t: output word with none outstanding", $time);
      mismatches_o++;
      return;
    end
    want = pending_reads.pop_front();
    if (got.i_bin !== want.i_bin) flag("i_bin_count", 64'(want.i_bin), 64'(got.i_bin));
    if (got.q_bin !== want.q_bin) flag("q_bin_count", 64'(want.q_bin), 64'(got.q_bin));
    if (got.i_tot !== want.i_tot) flag("i_total", 64'(want.i_tot), 64'(got.i_tot));
    if (got.q_tot !== want.q_tot) flag("q_total", 64'(want.q_tot), 64'(got.q_tot));
    if (got.i_sq !== want.i_sq) flag("i_square_total", 64'(want.i_sq), 64'(got.i_sq));
    if (got.q_sq !== want.q_sq) flag("q_square_total", 64'(want.q_sq), 64'(got.q_sq));
    if (got.pairs !== want.pairs) flag("pairs_counted", 64'(want.pairs), 64'(got.pairs));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spl_reg = iqh_pkg::SplReset;
      dec_reg = iqh_pkg::DecReset;
      clear_stats();
      pending_reads.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == iqh_pkg::RegSamplesPerLine)
          spl_reg = cfg_data_i[iqh_pkg::SplW-1:0];
        else if (cfg_index_i == iqh_pkg::RegLineDecimation)
          dec_reg = cfg_data_i[iqh_pkg::DecW-1:0];
      end
      if (out_valid_i && !out_stall_i)
        check_word({i_bin_count_i, q_bin_count_i, i_total_i, q_total_i,
                    i_square_total_i, q_square_total_i, pairs_counted_i});
      if (in_valid_i && !in_stall_i)
        apply_word(iqh_pkg::cmd_e'(command_i), i_sample_i, q_sample_i, bin_index_i);
      pending_o <= pending_reads.size();
    end
  end

  initial mismatches_o = 0;

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the I/Q histogram and moment accumulator with a directed opening
// (sample extremes, every command, zero registers, line length cut short
// mid-line) and then random phases over several register settings, with
// random gaps on both channels and one long output hold-off. The checker
// beside the block predicts and compares every response word.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [iqh_pkg::CfgIdxW-1:0] RegSpareLo = 2'd2;
  localparam logic [iqh_pkg::CfgIdxW-1:0] RegSpareHi = 2'd3;
  localparam int unsigned                 HoldCycles = 300;

  logic clk = 1'b0;
  logic rst_n;

  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [iqh_pkg::CfgIdxW-1:0]  cfg_index;
  logic [iqh_pkg::CfgDataW-1:0] cfg_data;
  logic                         in_valid;
  logic                         in_stall;
  logic [1:0]                   command;
  logic [7:0]                   i_sample, q_sample, bin_index;
  logic                         out_valid;
  logic                         out_stall;
  logic [31:0]                  i_bin_count, q_bin_count, pairs_counted;
  logic [39:0]                  i_total, q_total;
  logic [47:0]                  i_square_total, q_square_total;

  int unsigned pending;
  int unsigned mismatches;

  bit         src_calm;
  bit         sink_calm;
  bit         sink_hold_req;
  logic [7:0] last_i, last_q;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  iq_histogram_moment_accumulator_core DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .command_i        (command),
    .i_sample_i       (i_sample),
    .q_sample_i       (q_sample),
    .bin_index_i      (bin_index),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .i_bin_count_o    (i_bin_count),
    .q_bin_count_o    (q_bin_count),
    .i_total_o        (i_total),
    .q_total_o        (q_total),
    .i_square_total_o (i_square_total),
    .q_square_total_o (q_square_total),
    .pairs_counted_o  (pairs_counted)
  );

  iqh_stats_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .command_i        (command),
    .i_sample_i       (i_sample),
    .q_sample_i       (q_sample),
    .bin_index_i      (bin_index),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .i_bin_count_i    (i_bin_count),
    .q_bin_count_i    (q_bin_count),
    .i_total_i        (i_total),
    .q_total_i        (q_total),
    .i_square_total_i (i_square_total),
    .q_square_total_i (q_square_total),
    .pairs_counted_i  (pairs_counted),
    .pending_o        (pending),
    .mismatches_o     (mismatches)
  );

  // output side: random stall after each taken word, or one long hold-off
  initial begin : sink
    int unsigned pause;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rst_n && out_valid && !out_stall) begin
        pause = sink_calm ? 0 : $urandom_range(0, 9);
        if (pause != 0) begin
          out_stall <= 1'b1;
          repeat (pause) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  task automatic send_word(iqh_pkg::cmd_e cmd, logic [7:0] iv, logic [7:0] qv,
                           logic [7:0] bv);
    int unsigned gap;
    gap = src_calm ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= cmd;
    i_sample  <= iv;
    q_sample  <= qv;
    bin_index <= bv;
    if (cmd == iqh_pkg::CmdSample) begin
      last_i = iv;
      last_q = qv;
    end
    do @(posedge clk); while (in_stall);
  endtask

  // hold input until every read word has come back and the pipe is empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [iqh_pkg::CfgIdxW-1:0] idx,
                           logic [iqh_pkg::CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [iqh_pkg::SplW-1:0] spl, logic [iqh_pkg::DecW-1:0] dec);
    settle();
    write_reg(iqh_pkg::RegSamplesPerLine, spl);
    // upper byte is outside the register and must be dropped
    write_reg(iqh_pkg::RegLineDecimation, {8'($urandom), dec});
  endtask

  function automatic logic [7:0] pick_sample();
    return ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(120, 135));
  endfunction

  task automatic run_phase(logic [iqh_pkg::SplW-1:0] spl, logic [iqh_pkg::DecW-1:0] dec,
                           int unsigned count, bit hold_off);
    int unsigned pick;
    logic [7:0]  bv;
    configure(spl, dec);
    src_calm  = ($urandom_range(0, 3) == 0);
    sink_calm = ($urandom_range(0, 3) == 0);
    if (hold_off) begin
      src_calm      = 1'b1;
      sink_hold_req = 1'b1;
    end
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (hold_off) pick = (pick < 30) ? pick : 62 + pick % 36;
      case ($urandom_range(0, 2))
        0:       bv = last_i;
        1:       bv = last_q;
        default: bv = 8'($urandom);
      endcase
      if (pick < 62)
        send_word(iqh_pkg::CmdSample, pick_sample(), pick_sample(), 8'($urandom));
      else if (pick < 80)
        send_word(iqh_pkg::CmdReadBin, 8'($urandom), 8'($urandom), bv);
      else if (pick < 98)
        send_word(iqh_pkg::CmdReadTot, 8'($urandom), 8'($urandom), 8'($urandom));
      else
        send_word(iqh_pkg::CmdClear, 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin : stimulus
    cfg_valid     <= 1'b0;
    cfg_index     <= iqh_pkg::RegSamplesPerLine;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    command       <= iqh_pkg::CmdSample;
    i_sample      <= '0;
    q_sample      <= '0;
    bin_index     <= '0;
    rst_n         <= 1'b0;
    src_calm      = 1'b0;
    sink_calm     = 1'b0;
    sink_hold_req = 1'b0;
    last_i        = '0;
    last_q        = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: line 0 accumulates
    send_word(iqh_pkg::CmdReadTot, 8'h00, 8'h00, 8'h00);
    send_word(iqh_pkg::CmdReadBin, 8'h00, 8'h00, 8'h00);
    send_word(iqh_pkg::CmdReadBin, 8'h00, 8'h00, 8'hFF);
    send_word(iqh_pkg::CmdSample, 8'h00, 8'hFF, 8'h00);
    send_word(iqh_pkg::CmdSample, 8'hFF, 8'h00, 8'hFF);
    send_word(iqh_pkg::CmdSample, 8'hFF, 8'hFF, 8'h00);
    send_word(iqh_pkg::CmdSample, 8'h00, 8'h00, 8'hFF);
    send_word(iqh_pkg::CmdSample, 8'h55, 8'hAA, 8'h00);
    send_word(iqh_pkg::CmdReadBin, 8'hFF, 8'h00, 8'h00);
    send_word(iqh_pkg::CmdReadBin, 8'h00, 8'hFF, 8'hFF);
    send_word(iqh_pkg::CmdReadBin, 8'h00, 8'h00, 8'h55);
    send_word(iqh_pkg::CmdReadTot, 8'h00, 8'h00, 8'h00);
    send_word(iqh_pkg::CmdClear, 8'hFF, 8'hFF, 8'hFF);
    send_word(iqh_pkg::CmdReadTot, 8'h00, 8'h00, 8'h00);
    send_word(iqh_pkg::CmdReadBin, 8'h00, 8'h00, 8'hFF);

    // zero in both registers acts as one
    configure(16'd0, 8'd0);
    send_word(iqh_pkg::CmdSample, 8'h01, 8'h02, 8'h00);
    send_word(iqh_pkg::CmdSample, 8'h03, 8'h04, 8'h00);
    send_word(iqh_pkg::CmdReadTot, 8'h00, 8'h00, 8'h00);

    // shrink the line length below the current position
    configure(16'd8, 8'd3);
    repeat (5) send_word(iqh_pkg::CmdSample, 8'h10, 8'h20, 8'h00);
    configure(16'd2, 8'd3);
    send_word(iqh_pkg::CmdSample, 8'h30, 8'h40, 8'h00);
    send_word(iqh_pkg::CmdSample, 8'h50, 8'h60, 8'h00);
    send_word(iqh_pkg::CmdReadTot, 8'h00, 8'h00, 8'h00);

    // indexes with no register behind them
    settle();
    write_reg(RegSpareLo, 16'hFFFF);
    write_reg(RegSpareHi, 16'h0000);

    run_phase(16'd1, 8'd1, 90, 1'b0);
    run_phase(16'd0, 8'd0, 90, 1'b0);
    run_phase(16'd65535, 8'd255, 90, 1'b0);
    run_phase(16'd5, 8'd3, 100, 1'b1);
    run_phase(16'd1, 8'd255, 90, 1'b0);
    run_phase(16'd2, 8'd2, 90, 1'b0);
    repeat (4)
      run_phase(16'($urandom_range(1, 12)), 8'($urandom_range(1, 6)), 90, 1'b0);
    run_phase(16'd3, 8'd1, 90, 1'b0);

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #2400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### filelist.f
design/iqh_pkg.sv
design/iqh_hist_bank.sv
design/iqh_moments.sv
design/iq_histogram_moment_accumulator_core.sv
dv/iqh_stats_checker.sv
dv/testbench.sv
